// ----- rtl/tsaw_pkg.sv -----
// Shared constants, register codes and stage records of the texture sample
// address and weight unit.
// No dependencies.
package tsaw_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int MAX_LOG2_SIZE = 11;
  localparam int COORD_W       = 24;
  localparam int LVL_W         = 4;
  localparam int TEX_W         = 11;
  localparam int WT_W          = 17;
  localparam int MAG_W         = 35;
  localparam int NORM_W        = 31;
  localparam int SQR_W         = 62;
  localparam int SUM_W         = 63;
  localparam int MANT_W        = 32;
  localparam int LOG_FRAC      = 15;
  localparam int POS_W         = 36;
  localparam int INT_W         = POS_W - FRAC_BITS;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;

  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_MAG      = 3'd1,
    REG_MIN      = 3'd2,
    REG_WRAP_S   = 3'd3,
    REG_WRAP_T   = 3'd4,
    REG_LOG2_W   = 3'd5,
    REG_LOG2_H   = 3'd6,
    REG_MIP_CNT  = 3'd7
  } tsaw_reg_t;

  localparam logic [2:0] MIN_NEAREST = 3'd0;
  localparam logic [2:0] MIN_LINEAR  = 3'd1;
  localparam logic [2:0] MIN_NN_MIP  = 3'd2;
  localparam logic [2:0] MIN_LN_MIP  = 3'd3;
  localparam logic [2:0] MIN_NL_MIP  = 3'd4;
  localparam logic [2:0] MIN_LL_MIP  = 3'd5;
  localparam logic       WRAP_CLAMP  = 1'b0;
  localparam logic       MAG_LINEAR  = 1'b1;

  localparam logic [WT_W-1:0] WT_ONE = WT_W'(1 << FRAC_BITS);

  typedef struct packed {
    logic signed [COORD_W-1:0] s;
    logic signed [COORD_W-1:0] t;
  } tsaw_coord_t;

  typedef struct packed {
    logic            white;
    logic            lin;
    logic            two;
    logic [LVL_W-1:0] lvl0;
    logic [WT_W-1:0]  wm0;
    logic [WT_W-1:0]  wm1;
  } tsaw_sel_t;

  typedef struct packed {
    logic [3:0]              sw;
    logic [3:0]              sh;
    logic signed [INT_W-1:0] iu;
    logic signed [INT_W-1:0] iv;
    logic [15:0]             a;
    logic [15:0]             b;
  } tsaw_lvl_t;

  typedef struct packed {
    logic [TEX_W-1:0] x0;
    logic [TEX_W-1:0] x1;
    logic [TEX_W-1:0] y0;
    logic [TEX_W-1:0] y1;
  } tsaw_addr_t;

endpackage

// ----- rtl/texture_sample_address_weights_unit.sv -----
// Texture sample address and weight unit: level of detail, filter choice,
// wrapped texel addresses and blend weights. Uses tsaw_pkg.
//
// Usage: the sample channel (sample_valid / sample_stall) takes one word per
// sample: the coordinate (coord_s, coord_t) and its four screen derivatives,
// signed with 16 fraction bits. The fetch channel (fetch_valid / fetch_stall)
// returns one word per texel fetch: level, texel_x, texel_y, a 1.16 weight,
// and last_fetch on the final word of the sample. A disabled unit returns a
// single word with use_white set. A sample gives 1, 2, 4 or 8 fetch words.
// The level of detail logarithm does one squaring of the mantissa per stage.
// A sample can enter every cycle while the pipeline is not held; sustained
// rate is set by the single fetch output, one word a cycle while the receiver
// does not stall, so a trilinear sample gives 8 fetch words. When the receiver
// stalls, the whole pipeline holds and sample_stall rises; nothing is lost or
// repeated. Reset (synchronous, rst) empties the pipeline and loads the
// register reset values. Registers are written over the APB port at byte
// address 4*index; the user must write them only while idle (not enforced).
module texture_sample_address_weights_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tsaw_pkg::ADDR_W-1:0]         paddr,
  input  logic [tsaw_pkg::DATA_W-1:0]         pwdata,
  output logic [tsaw_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [tsaw_pkg::COORD_W-1:0] coord_s,
  input  logic signed [tsaw_pkg::COORD_W-1:0] coord_t,
  input  logic signed [tsaw_pkg::COORD_W-1:0] dsdx,
  input  logic signed [tsaw_pkg::COORD_W-1:0] dtdx,
  input  logic signed [tsaw_pkg::COORD_W-1:0] dsdy,
  input  logic signed [tsaw_pkg::COORD_W-1:0] dtdy,
  output logic                                fetch_valid,
  input  logic                                fetch_stall,
  output logic                                use_white,
  output logic [tsaw_pkg::LVL_W-1:0]          level,
  output logic [tsaw_pkg::TEX_W-1:0]          texel_x,
  output logic [tsaw_pkg::TEX_W-1:0]          texel_y,
  output logic [tsaw_pkg::WT_W-1:0]           weight,
  output logic                                last_fetch
);
  import tsaw_pkg::*;

  // Configuration registers.
  logic       cfg_en, cfg_mag, cfg_wrap_s, cfg_wrap_t;
  logic [2:0] cfg_min;
  logic [3:0] cfg_lw, cfg_lh, cfg_mc;
  tsaw_reg_t  wr_reg, rd_reg;

  assign pready = 1'b1;
  assign wr_reg = tsaw_reg_t'(paddr[ADDR_W-1:2]);
  assign rd_reg = tsaw_reg_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_en     <= 1'b0;
      cfg_mag    <= 1'b1;
      cfg_min    <= MIN_NEAREST;
      cfg_wrap_s <= 1'b1;
      cfg_wrap_t <= 1'b1;
      cfg_lw     <= 4'd0;
      cfg_lh     <= 4'd0;
      cfg_mc     <= 4'd1;
    end else if (psel && penable && pwrite) begin
      unique case (wr_reg)
        REG_ENABLE:  cfg_en     <= pwdata[0];
        REG_MAG:     cfg_mag    <= pwdata[0];
        REG_MIN:     cfg_min    <= pwdata[2:0];
        REG_WRAP_S:  cfg_wrap_s <= pwdata[0];
        REG_WRAP_T:  cfg_wrap_t <= pwdata[0];
        REG_LOG2_W:  cfg_lw     <= pwdata[3:0];
        REG_LOG2_H:  cfg_lh     <= pwdata[3:0];
        REG_MIP_CNT: cfg_mc     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (rd_reg)
      REG_ENABLE:  prdata = DATA_W'(cfg_en);
      REG_MAG:     prdata = DATA_W'(cfg_mag);
      REG_MIN:     prdata = DATA_W'(cfg_min);
      REG_WRAP_S:  prdata = DATA_W'(cfg_wrap_s);
      REG_WRAP_T:  prdata = DATA_W'(cfg_wrap_t);
      REG_LOG2_W:  prdata = DATA_W'(cfg_lw);
      REG_LOG2_H:  prdata = DATA_W'(cfg_lh);
      REG_MIP_CNT: prdata = DATA_W'(cfg_mc);
      default:     prdata = '0;
    endcase
  end

  // Register values as the datapath sees them: sizes and level count are
  // clamped to the supported range, unknown minification codes act as
  // nearest.
  logic [3:0] lw, lh, mc, mc_m1;
  logic [2:0] mf;
  assign lw    = (cfg_lw > 4'(MAX_LOG2_SIZE)) ? 4'(MAX_LOG2_SIZE) : cfg_lw;
  assign lh    = (cfg_lh > 4'(MAX_LOG2_SIZE)) ? 4'(MAX_LOG2_SIZE) : cfg_lh;
  assign mc    = (cfg_mc == 4'd0) ? 4'd1 :
                 (cfg_mc > 4'(MAX_LOG2_SIZE + 1)) ? 4'(MAX_LOG2_SIZE + 1) : cfg_mc;
  assign mc_m1 = mc - 4'd1;
  assign mf    = (cfg_min > MIN_LL_MIP) ? MIN_NEAREST : cfg_min;

  function automatic logic [MAG_W-1:0] scale_mag(input logic signed [COORD_W-1:0] d,
                                                 input logic [3:0] sh);
    logic [COORD_W-1:0] mag;
    mag = d[COORD_W-1] ? COORD_W'(-d) : COORD_W'(d);
    return MAG_W'(mag) << sh;
  endfunction

  function automatic logic [TEX_W-1:0] wrap_coord(input logic mode, input logic [3:0] sz,
                                                  input logic signed [INT_W:0] v);
    logic [TEX_W:0] mask;
    mask = (TEX_W+1)'((TEX_W+1)'(1) << sz) - (TEX_W+1)'(1);
    if (mode == WRAP_CLAMP) begin
      if (v < 0) return '0;
      else if (v > $signed({{(INT_W-TEX_W){1'b0}}, mask})) return mask[TEX_W-1:0];
      else return v[TEX_W-1:0];
    end
    return v[TEX_W-1:0] & mask[TEX_W-1:0];
  endfunction

  // The whole pipeline moves together; it holds only while the fetch
  // serializer still has words of an earlier sample to hand out.
  logic adv;
  logic ser_v;

  // Stage 1: scaled derivative magnitudes.
  logic             v1;
  tsaw_coord_t      c1;
  logic [MAG_W-1:0] m1 [4];
  // Stage 2: common right shift keeps every magnitude below 2^31.
  logic              v2;
  tsaw_coord_t       c2;
  logic [2:0]        k2;
  logic [NORM_W-1:0] m2 [4];
  logic [MAG_W-1:0]  orv;
  logic [2:0]        k_next;
  // Stage 3: squares.
  logic             v3;
  tsaw_coord_t      c3;
  logic [2:0]       k3;
  logic [SQR_W-1:0] sq3 [4];
  // Stage 4: larger squared length.
  logic             v4;
  tsaw_coord_t      c4;
  logic [2:0]       k4;
  logic [SUM_W-1:0] q4;
  logic [SUM_W-1:0] qx, qy;
  // Stage 5: position of the top set bit.
  logic             v5, z5;
  tsaw_coord_t      c5;
  logic [2:0]       k5;
  logic [SUM_W-1:0] q5;
  logic [5:0]       p5, p_next;
  // Stage 6: normalized 1.31 mantissa.
  logic              v6, z6;
  tsaw_coord_t       c6;
  logic [2:0]        k6;
  logic [5:0]        p6;
  logic [MANT_W-1:0] x6;
  logic [SUM_W-1:0]  qn;

  always_comb begin
    orv = m1[0] | m1[1] | m1[2] | m1[3];
    k_next = 3'd0;
    for (int b = NORM_W; b < MAG_W; b++) begin
      if (orv[b]) k_next = 3'(b - NORM_W + 1);
    end
    qx = SUM_W'(sq3[0]) + SUM_W'(sq3[1]);
    qy = SUM_W'(sq3[2]) + SUM_W'(sq3[3]);
    p_next = 6'd0;
    for (int b = 0; b < SUM_W; b++) begin
      if (q4[b]) p_next = 6'(b);
    end
    qn = q5 << (6'(SUM_W - 1) - p5);
  end

  // Fraction of the logarithm: one squaring of the mantissa per stage.
  logic              sv   [LOG_FRAC];
  logic              sz   [LOG_FRAC];
  tsaw_coord_t       sc   [LOG_FRAC];
  logic [2:0]        sk   [LOG_FRAC];
  logic [5:0]        sp   [LOG_FRAC];
  logic [MANT_W-1:0] sx   [LOG_FRAC];
  logic [LOG_FRAC-1:0] sf [LOG_FRAC];
  logic [MANT_W-1:0] sx_in  [LOG_FRAC];
  logic [LOG_FRAC-1:0] sf_in [LOG_FRAC];
  logic [MANT_W-1:0] sx_next [LOG_FRAC];
  logic [LOG_FRAC-1:0] sf_next [LOG_FRAC];
  logic [2*MANT_W-1:0] sprod [LOG_FRAC];

  always_comb begin
    for (int j = 0; j < LOG_FRAC; j++) begin
      sx_in[j] = (j == 0) ? x6 : sx[(j == 0) ? 0 : j - 1];
      sf_in[j] = (j == 0) ? '0 : sf[(j == 0) ? 0 : j - 1];
      sprod[j] = (2*MANT_W)'(sx_in[j]) * (2*MANT_W)'(sx_in[j]);
      sf_next[j] = {sf_in[j][LOG_FRAC-2:0], sprod[j][2*MANT_W-1]};
      sx_next[j] = sprod[j][2*MANT_W-1] ? sprod[j][2*MANT_W-1:MANT_W]
                                        : sprod[j][2*MANT_W-2:MANT_W-1];
    end
  end

  // Stage 7: lambda and filter decision.
  logic        v7;
  tsaw_coord_t c7;
  tsaw_sel_t   sel7, sel_next;
  logic signed [7:0]  ip;
  logic signed [23:0] lam, cval, rsum;
  logic signed [7:0]  lr, ln, lf, mcm1;
  localparam int LAST = LOG_FRAC - 1;

  always_comb begin
    ip   = $signed({2'b00, sp[LAST]}) + $signed({4'b0000, sk[LAST], 1'b0}) - 8'sd32;
    lam  = {ip[7], ip, sf[LAST]};
    cval = (cfg_mag == MAG_LINEAR && (mf == MIN_NN_MIP || mf == MIN_NL_MIP)) ?
           24'sd32768 : 24'sd0;
    rsum = lam + 24'sd98303;
    lr   = rsum[23:16];
    ln   = lr - 8'sd1;
    lf   = lam[23:16];
    mcm1 = $signed({4'b0000, mc_m1});
    sel_next.white = !cfg_en;
    sel_next.lin   = 1'b0;
    sel_next.two   = 1'b0;
    sel_next.lvl0  = '0;
    sel_next.wm0   = WT_ONE;
    sel_next.wm1   = '0;
    priority if (sz[LAST] || lam < cval) begin
      sel_next.lin = (cfg_mag == MAG_LINEAR);
    end else if (mf == MIN_NEAREST || mf == MIN_LINEAR) begin
      sel_next.lin = (mf == MIN_LINEAR);
    end else if (mf == MIN_NN_MIP || mf == MIN_LN_MIP) begin
      sel_next.lin = (mf == MIN_LN_MIP);
      if (ln < 0) sel_next.lvl0 = '0;
      else if (ln > mcm1) sel_next.lvl0 = mc_m1;
      else sel_next.lvl0 = ln[3:0];
    end else begin
      sel_next.lin = (mf == MIN_LL_MIP);
      if (lf >= mcm1) begin
        sel_next.lvl0 = mc_m1;
      end else begin
        sel_next.lvl0 = lf[3:0];
        sel_next.two  = 1'b1;
        sel_next.wm1  = {1'b0, lam[15:0]};
        sel_next.wm0  = WT_ONE - {1'b0, lam[15:0]};
      end
    end
  end

  // Stage 8: level coordinates, integer texel and fraction per axis.
  logic      v8;
  tsaw_sel_t sel8;
  tsaw_lvl_t lv8 [2];
  tsaw_lvl_t lv_next [2];
  logic [3:0] lvl_j [2];
  logic signed [POS_W-1:0] su [2];
  logic signed [POS_W-1:0] tv [2];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      lvl_j[j] = sel7.lvl0 + 4'(j);
      lv_next[j].sw = (lw > lvl_j[j]) ? lw - lvl_j[j] : 4'd0;
      lv_next[j].sh = (lh > lvl_j[j]) ? lh - lvl_j[j] : 4'd0;
      su[j] = (POS_W'(c7.s) <<< lv_next[j].sw) -
              (sel7.lin ? POS_W'(1 << (FRAC_BITS - 1)) : POS_W'(0));
      tv[j] = (POS_W'(c7.t) <<< lv_next[j].sh) -
              (sel7.lin ? POS_W'(1 << (FRAC_BITS - 1)) : POS_W'(0));
      lv_next[j].iu = su[j][POS_W-1:FRAC_BITS];
      lv_next[j].iv = tv[j][POS_W-1:FRAC_BITS];
      lv_next[j].a  = su[j][15:0];
      lv_next[j].b  = tv[j][15:0];
    end
  end

  // Stage 9: wrapped addresses and bilinear weights.
  logic       v9;
  tsaw_sel_t  sel9;
  tsaw_addr_t ad9 [2];
  tsaw_addr_t ad_next [2];
  logic [WT_W-1:0] bl9 [2][4];
  logic [WT_W-1:0] bl_next [2][4];
  logic [WT_W-1:0] oa [2];
  logic [WT_W-1:0] ob [2];
  logic [2*WT_W-1:0] bp [2][4];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      ad_next[j].x0 = wrap_coord(cfg_wrap_s, lv8[j].sw, (INT_W+1)'(lv8[j].iu));
      ad_next[j].x1 = wrap_coord(cfg_wrap_s, lv8[j].sw,
                                 (INT_W+1)'(lv8[j].iu) + (INT_W+1)'(1));
      ad_next[j].y0 = wrap_coord(cfg_wrap_t, lv8[j].sh, (INT_W+1)'(lv8[j].iv));
      ad_next[j].y1 = wrap_coord(cfg_wrap_t, lv8[j].sh,
                                 (INT_W+1)'(lv8[j].iv) + (INT_W+1)'(1));
      oa[j] = WT_ONE - {1'b0, lv8[j].a};
      ob[j] = WT_ONE - {1'b0, lv8[j].b};
      bp[j][0] = (2*WT_W)'(oa[j]) * (2*WT_W)'(ob[j]);
      bp[j][1] = (2*WT_W)'(lv8[j].a) * (2*WT_W)'(ob[j]);
      bp[j][2] = (2*WT_W)'(oa[j]) * (2*WT_W)'(lv8[j].b);
      bp[j][3] = (2*WT_W)'(lv8[j].a) * (2*WT_W)'(lv8[j].b);
      for (int n = 0; n < 4; n++) bl_next[j][n] = bp[j][n][32:16];
    end
  end

  // Stage 10: weights scaled by the level blend factor.
  logic       v10;
  tsaw_sel_t  sel10;
  tsaw_addr_t ad10 [2];
  logic [WT_W-1:0] w10 [2][4];
  logic [WT_W-1:0] w_next [2][4];
  logic [WT_W-1:0] wm9 [2];
  logic [2*WT_W-1:0] wp [2][4];

  always_comb begin
    wm9[0] = sel9.wm0;
    wm9[1] = sel9.wm1;
    for (int j = 0; j < 2; j++) begin
      for (int n = 0; n < 4; n++) begin
        wp[j][n] = (2*WT_W)'(bl9[j][n]) * (2*WT_W)'(wm9[j]);
        w_next[j][n] = sel9.lin ? wp[j][n][32:16] : wm9[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0; v10 <= 1'b0;
      for (int j = 0; j < LOG_FRAC; j++) sv[j] <= 1'b0;
    end else if (adv) begin
      v1 <= sample_valid;
      c1.s <= coord_s;
      c1.t <= coord_t;
      m1[0] <= scale_mag(dsdx, lw);
      m1[1] <= scale_mag(dtdx, lh);
      m1[2] <= scale_mag(dsdy, lw);
      m1[3] <= scale_mag(dtdy, lh);

      v2 <= v1; c2 <= c1; k2 <= k_next;
      for (int i = 0; i < 4; i++) m2[i] <= NORM_W'(m1[i] >> k_next);

      v3 <= v2; c3 <= c2; k3 <= k2;
      for (int i = 0; i < 4; i++) sq3[i] <= SQR_W'(m2[i]) * SQR_W'(m2[i]);

      v4 <= v3; c4 <= c3; k4 <= k3;
      q4 <= (qx > qy) ? qx : qy;

      v5 <= v4; c5 <= c4; k5 <= k4; q5 <= q4; p5 <= p_next;
      z5 <= (q4 == '0);

      v6 <= v5; c6 <= c5; k6 <= k5; p6 <= p5; z6 <= z5;
      x6 <= qn[SUM_W-1 -: MANT_W];

      for (int j = 0; j < LOG_FRAC; j++) begin
        sv[j] <= (j == 0) ? v6 : sv[(j == 0) ? 0 : j - 1];
        sz[j] <= (j == 0) ? z6 : sz[(j == 0) ? 0 : j - 1];
        sc[j] <= (j == 0) ? c6 : sc[(j == 0) ? 0 : j - 1];
        sk[j] <= (j == 0) ? k6 : sk[(j == 0) ? 0 : j - 1];
        sp[j] <= (j == 0) ? p6 : sp[(j == 0) ? 0 : j - 1];
        sx[j] <= sx_next[j];
        sf[j] <= sf_next[j];
      end

      v7 <= sv[LAST]; c7 <= sc[LAST]; sel7 <= sel_next;
      v8 <= v7; sel8 <= sel7; lv8 <= lv_next;
      v9 <= v8; sel9 <= sel8; ad9 <= ad_next; bl9 <= bl_next;
      v10 <= v9; sel10 <= sel9; ad10 <= ad9; w10 <= w_next;
    end
  end

  // Fetch serializer: holds one sample's fetches and hands out one word per
  // cycle unless fetch_stall holds it, in level, then row, then column order.
  tsaw_sel_t       o_sel;
  tsaw_addr_t      o_ad [2];
  logic [WT_W-1:0] o_w [2][4];
  logic [2:0]      o_idx, o_last;
  logic            o_j;
  logic [1:0]      o_cn;

  assign adv          = !ser_v || (!fetch_stall && last_fetch);
  assign sample_stall = !adv;
  assign fetch_valid  = ser_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_v <= 1'b0;
      o_idx <= '0;
    end else if (adv) begin
      ser_v <= v10;
      o_idx <= '0;
      o_sel <= sel10;
      o_ad  <= ad10;
      o_w   <= w10;
      if (sel10.white) o_last <= 3'd0;
      else o_last <= {sel10.lin && sel10.two, sel10.lin,
                      sel10.lin || sel10.two};
    end else if (fetch_valid && !fetch_stall) begin
      o_idx <= o_idx + 3'd1;
    end
  end

  always_comb begin
    o_j  = o_sel.lin ? o_idx[2] : o_idx[0];
    o_cn = o_sel.lin ? o_idx[1:0] : 2'd0;
    use_white  = o_sel.white;
    last_fetch = (o_idx == o_last);
    if (o_sel.white) begin
      level   = '0;
      texel_x = '0;
      texel_y = '0;
      weight  = '0;
    end else begin
      level   = o_sel.lvl0 + LVL_W'(o_j);
      texel_x = o_cn[0] ? o_ad[o_j].x1 : o_ad[o_j].x0;
      texel_y = o_cn[1] ? o_ad[o_j].y1 : o_ad[o_j].y0;
      weight  = o_w[o_j][o_cn];
    end
  end

`ifndef SYNTHESIS
  a_white_single: assert property (@(posedge clk) disable iff (rst)
    fetch_valid && use_white |-> last_fetch && level == '0 && weight == '0)
    else $error("white sample must be a single empty word");
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    fetch_valid |-> weight <= WT_ONE)
    else $error("fetch weight above one");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    ser_v |-> o_idx <= o_last)
    else $error("serializer index past the last fetch");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    ser_v && fetch_stall |=> ser_v && $stable(o_idx))
    else $error("serializer moved while stalled");
`endif

endmodule
